@@ rtl/rse_pkg.sv @@
// Shared widths, command codes and LFSR helpers of the randomized set engine.
package rse_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 64;
    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned SIZE_W           = 7;
    localparam int unsigned RAND_W           = 32;
    localparam int unsigned IN_TDATA_W       = 40;
    localparam int unsigned OUT_TDATA_W      = 40;

    localparam logic [RAND_W-1:0] LFSR_MASK  = 32'h8020_0003;
    localparam logic [RAND_W-1:0] SEED_RESET = 32'd1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PICK   = 2'd2
    } cmd_t;

    // A zero seed would lock the generator, so it is replaced by one.
    function automatic logic [RAND_W-1:0] seed_or_one(input logic [RAND_W-1:0] s);
        return (s != '0) ? s : SEED_RESET;
    endfunction

    // Right-shifting Galois LFSR step.
    function automatic logic [RAND_W-1:0] lfsr_next(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] t;
        t = s >> 1;
        if (s[0])
        begin
            t = t ^ LFSR_MASK;
        end
        return t;
    endfunction

endpackage

@@ rtl/rse_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module rse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rse_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module rse_mod #(
    parameter int unsigned DIVISOR_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rse_pkg::RAND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        done,
    output logic [DIVISOR_W-1:0]        remainder
);

    localparam int unsigned IW = $clog2(rse_pkg::RAND_W);

    logic [rse_pkg::RAND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]       dsr_reg;
    logic [DIVISOR_W-1:0]       rem_reg;
    logic [IW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DIVISOR_W:0]         trial;
    logic [DIVISOR_W:0]         diff;
    logic [DIVISOR_W-1:0]       rem_next;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[rse_pkg::RAND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= IW'(rse_pkg::RAND_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - IW'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/randomized_set_engine_top.sv @@
// Top level of the randomized set engine: control sequencer, value store and LFSR.
// Insert and remove run a linear scan that reads one store entry per cycle; a remove that
// frees a slot below the last element then moves the last element into it; a random pick
// runs the bit-serial remainder unit and then reads the picked store entry.
// Throughput: one item at a time; the next input beat is taken once the result is queued.
// Reset: asynchronous active-low; the set is empty, the seed is 1, the store is not cleared.
module randomized_set_engine_top #(
    parameter int unsigned CAPACITY = rse_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream. s_tdata fields from bit 0: cmd[1:0], item_value[33:2], zero pad.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rse_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Result stream. m_tdata fields from bit 0: success[0], picked_value[32:1],
    // set_size[39:33].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rse_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Seed register write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rse_pkg::RAND_W-1:0]          cfg_data
);

    // Count width holds CAPACITY itself; address width indexes the store.
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DIV,
        S_PICK_DATA,
        S_RESULT
    } state_t;

    state_t                         state_reg;
    rse_pkg::cmd_t                  cmd_reg;
    logic [rse_pkg::VALUE_W-1:0]    val_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  issue_idx_reg;
    logic [CW-1:0]                  cmp_idx_reg;
    logic                           cmp_valid_reg;
    logic [CW-1:0]                  slot_reg;
    logic [rse_pkg::RAND_W-1:0]     rand_reg;
    logic                           res_success_reg;
    logic [rse_pkg::VALUE_W-1:0]    res_picked_reg;
    logic                           out_valid_reg;
    logic [rse_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic                           in_beat;
    rse_pkg::cmd_t                  in_cmd;
    logic [rse_pkg::VALUE_W-1:0]    in_val;
    logic [rse_pkg::RAND_W-1:0]     rand_step;
    logic                           div_start;
    logic                           div_done;
    logic [CW-1:0]                  div_rem;
    logic                           hit;
    logic                           more;
    logic [CW-1:0]                  last_idx;
    logic                           mem_we;
    logic [AW-1:0]                  mem_wr_addr;
    logic [rse_pkg::VALUE_W-1:0]    mem_wr_data;
    logic                           mem_re;
    logic [AW-1:0]                  mem_rd_addr;
    logic [rse_pkg::VALUE_W-1:0]    mem_rd_data;
    logic                           out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign in_cmd    = rse_pkg::cmd_t'(s_tdata[1:0]);
    assign in_val    = s_tdata[rse_pkg::VALUE_W+1:2];
    assign rand_step = rse_pkg::lfsr_next(rand_reg);
    assign last_idx  = count_reg - CW'(1);

    // A pick on a non-empty set starts the remainder unit at once and advances the LFSR unless a seed write wins.
    assign div_start = in_beat && (in_cmd == rse_pkg::CMD_PICK) && (count_reg != '0);

    // The scan is pipelined: an entry read issued in one cycle is compared in the next.
    // A miss is known once every entry below the count has been issued and compared.
    assign hit  = cmp_valid_reg && (mem_rd_data == val_reg);
    assign more = (issue_idx_reg < count_reg);

    // Store port control. Reads and writes of one item are ordered by the sequencer,
    // so a read never targets an entry written in the same cycle.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_wr_addr = count_reg[AW-1:0];
        mem_wr_data = val_reg;
        mem_re      = 1'b0;
        mem_rd_addr = issue_idx_reg[AW-1:0];
        case (state_reg)
            S_SCAN:
            begin
                if (!hit && more)
                begin
                    mem_re = 1'b1;
                end
                else if (!hit && (cmd_reg == rse_pkg::CMD_INSERT)
                         && (count_reg < CW'(CAPACITY)))
                begin
                    mem_we = 1'b1;
                end
            end
            S_MOVE_RD:
            begin
                mem_re      = 1'b1;
                mem_rd_addr = last_idx[AW-1:0];
            end
            S_MOVE_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = slot_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
            end
            S_DIV:
            begin
                mem_re      = div_done;
                mem_rd_addr = div_rem[AW-1:0];
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // The finished result enters the output register when it is empty or being drained.
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= rse_pkg::CMD_INSERT;
            val_reg         <= '0;
            count_reg       <= '0;
            issue_idx_reg   <= '0;
            cmp_idx_reg     <= '0;
            cmp_valid_reg   <= 1'b0;
            slot_reg        <= '0;
            rand_reg        <= rse_pkg::SEED_RESET;
            res_success_reg <= 1'b0;
            res_picked_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // The seed register loads the generator directly; the user must write it only when idle (not enforced).
            if (cfg_valid && cfg_ready)
            begin
                rand_reg <= rse_pkg::seed_or_one(cfg_data);
            end
            else if (div_start)
            begin
                rand_reg <= rand_step;
            end

            // A drained beat empties the register unless a new result replaces it.
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        cmd_reg         <= in_cmd;
                        val_reg         <= in_val;
                        issue_idx_reg   <= '0;
                        cmp_valid_reg   <= 1'b0;
                        res_success_reg <= 1'b0;
                        res_picked_reg  <= '0;
                        case (in_cmd)
                            rse_pkg::CMD_INSERT, rse_pkg::CMD_REMOVE:
                            begin
                                state_reg <= S_SCAN;
                            end
                            rse_pkg::CMD_PICK:
                            begin
                                // An empty set answers at once without a pick.
                                state_reg <= (count_reg != '0) ? S_DIV : S_RESULT;
                            end
                            default:
                            begin
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        cmp_valid_reg <= 1'b0;
                        if (cmd_reg == rse_pkg::CMD_REMOVE)
                        begin
                            // Removing the last element needs no move.
                            res_success_reg <= 1'b1;
                            slot_reg        <= cmp_idx_reg;
                            if (cmp_idx_reg != last_idx)
                            begin
                                state_reg <= S_MOVE_RD;
                            end
                            else
                            begin
                                count_reg <= last_idx;
                                state_reg <= S_RESULT;
                            end
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                    else if (more)
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= issue_idx_reg;
                        issue_idx_reg <= issue_idx_reg + CW'(1);
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                        if (mem_we)
                        begin
                            count_reg       <= count_reg + CW'(1);
                            res_success_reg <= 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_MOVE_RD:
                begin
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR:
                begin
                    count_reg <= last_idx;
                    state_reg <= S_RESULT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_PICK_DATA;
                    end
                end
                S_PICK_DATA:
                begin
                    res_success_reg <= 1'b1;
                    res_picked_reg  <= mem_rd_data;
                    state_reg       <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {rse_pkg::SIZE_W'(count_reg), res_picked_reg,
                                          res_success_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    rse_ram #(
        .WIDTH (rse_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rse_mod #(
        .DIVISOR_W (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_step),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // The element count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    // A store write lands at or below the current count.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, mem_wr_addr} <= (AW + 1)'(count_reg)))
        else $error("store write beyond the packed region");

    // The picked index lies inside the packed region.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && div_done |-> (div_rem < count_reg))
        else $error("pick index outside the set");

    // The remainder unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder finished outside a pick");

    // The count moves only on the way to the result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_RESULT))
        else $error("element count changed outside an operation");

endmodule
